### hdl/bti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_pkg
// Shared types and constants of the bilinear table interpolator.
// ----------------------------------------------------------------------------
package bti_pkg;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [12:0] ONE_Q12 = 13'd4096;

  localparam int IN_DEPTH  = 4;
  localparam int OUT_DEPTH = 8;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TEMP_LOW  = 2'd1,
    ST_TEMP_HIGH = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_TEMP_ORIGIN = 3'd0,
    REG_TEMP_INV    = 3'd1,
    REG_TEMP_LAST   = 3'd2,
    REG_GRAV_ORIGIN = 3'd3,
    REG_GRAV_INV    = 3'd4,
    REG_GRAV_LAST   = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [19:0] temp_origin;
    logic [23:0] temp_inv;
    logic [4:0]  temp_last;
    logic [15:0] grav_origin;
    logic [23:0] grav_inv;
    logic [3:0]  grav_last;
  } cfg_t;

  typedef struct packed {
    logic        func;
    logic [2:0]  filt;
    logic [3:0]  gslot;
    logic [4:0]  tslot;
    logic [31:0] value;
    logic        t_low;
    logic [23:0] tpos;
    logic        g_low;
    logic [19:0] gpos;
  } front_word_t;

  typedef struct packed {
    logic [31:0] intensity;
    status_t     status;
  } result_t;

endpackage

### hdl/bti_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_queue
// Small register queue with a combinational head; depth is a power of two.
// ----------------------------------------------------------------------------
module bti_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty,
  output logic             full
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;

  assign head_data = mem_r[rd_ptr_r];
  assign empty     = (count_r == '0);
  assign full      = (count_r == (PW+1)'(DEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

### hdl/bti_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_bank
// One table bank: one write port and one registered read port.
// ----------------------------------------------------------------------------
module bti_bank #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### hdl/bti_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_front
// Accepts words and maps temperature and gravity to Q12 grid positions.
// ----------------------------------------------------------------------------
module bti_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bti_pkg::cfg_t        cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_func,
  input  logic [19:0]          in_temperature,
  input  logic [15:0]          in_log_gravity,
  input  logic [2:0]           in_filter_index,
  input  logic [3:0]           in_grav_slot,
  input  logic [4:0]           in_temp_slot,
  input  logic [31:0]          in_entry_value,
  input  logic                 q_full,
  output logic                 q_push,
  output bti_pkg::front_word_t q_word
);
  logic                 valid_r;
  bti_pkg::front_word_t word_r, word_nxt;
  logic                 take;
  logic [19:0]          tdiff;
  logic [15:0]          gdiff;
  logic [43:0]          tprod;
  logic [39:0]          gprod;

  assign in_stall = valid_r && q_full;
  assign take     = in_valid && !in_stall;
  assign q_push   = valid_r && !q_full;
  assign q_word   = word_r;

  always_comb begin
    tdiff = in_temperature - cfg.temp_origin;
    gdiff = in_log_gravity - cfg.grav_origin;
    tprod = 44'(tdiff) * 44'(cfg.temp_inv);
    gprod = 40'(gdiff) * 40'(cfg.grav_inv);
    word_nxt.func  = in_func;
    word_nxt.filt  = in_filter_index;
    word_nxt.gslot = in_grav_slot;
    word_nxt.tslot = in_temp_slot;
    word_nxt.value = in_entry_value;
    word_nxt.t_low = (in_temperature <= cfg.temp_origin);
    word_nxt.tpos  = tprod[43:20];
    word_nxt.g_low = (in_log_gravity <= cfg.grav_origin);
    word_nxt.gpos  = gprod[39:20];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (q_push) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r <= word_nxt;
    end
  end
endmodule

### hdl/bti_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_back
// Writes table entries and runs lookups through four parity banks and a
// multiply and sum pipeline.
// ----------------------------------------------------------------------------
module bti_back #(
  parameter int TEMP_POINTS = 32,
  parameter int GRAV_POINTS = 16,
  parameter int FILTERS     = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bti_pkg::cfg_t        cfg,
  input  logic                 q_empty,
  input  bti_pkg::front_word_t head,
  output logic                 q_pop,
  input  logic                 res_taken,
  output logic                 res_push,
  output bti_pkg::result_t     res_word
);
  localparam int GH = (GRAV_POINTS + 1) / 2;
  localparam int TH = (TEMP_POINTS + 1) / 2;
  localparam int BD = GH * TH * FILTERS;
  localparam int AW = (BD > 1) ? $clog2(BD) : 1;
  localparam int CW = $clog2(bti_pkg::OUT_DEPTH + 1);

  logic             is_lookup, lookup_pop;
  logic [CW-1:0]    pending_r, pending_nxt;
  bti_pkg::status_t status;
  logic [5:0]       t1, t2;
  logic [4:0]       g1, g2;
  logic [12:0]      wt1, wt2, wg1, wg2;

  logic             s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  bti_pkg::status_t s1_st_r, s2_st_r, s3_st_r, s4_st_r;
  logic [12:0]      s1_wg_r [4];
  logic [12:0]      s1_wt_r [4];
  logic             s1_ok_r [4];
  logic [31:0]      rdata   [4];
  logic [25:0]      s2_ww_r [4];
  logic [31:0]      s2_d_r  [4];
  logic [57:0]      s3_p_r  [4];
  logic [57:0]      s4_a_r, s4_b_r;
  logic [57:0]      total;

  assign is_lookup  = (head.func == bti_pkg::FUNC_LOOKUP);
  assign q_pop      = !q_empty &&
                      (!is_lookup || (pending_r < CW'(bti_pkg::OUT_DEPTH)));
  assign lookup_pop = q_pop && is_lookup;
  assign pending_nxt = pending_r + CW'(lookup_pop) - CW'(res_taken);

  always_comb begin
    priority if (head.t_low) begin
      status = bti_pkg::ST_TEMP_LOW;
    end else if (head.tpos >= 24'({cfg.temp_last, 12'd0})) begin
      status = bti_pkg::ST_TEMP_HIGH;
    end else begin
      status = bti_pkg::ST_OK;
    end
    t1  = {1'b0, head.tpos[16:12]};
    t2  = t1 + 6'd1;
    wt2 = {1'b0, head.tpos[11:0]};
    wt1 = bti_pkg::ONE_Q12 - wt2;
    priority if (head.g_low) begin
      g1  = '0;
      g2  = '0;
      wg2 = '0;
    end else if (head.gpos >= 20'({cfg.grav_last, 12'd0})) begin
      g1  = {1'b0, cfg.grav_last};
      g2  = {1'b0, cfg.grav_last};
      wg2 = '0;
    end else begin
      g1  = {1'b0, head.gpos[15:12]};
      g2  = g1 + 5'd1;
      wg2 = {1'b0, head.gpos[11:0]};
    end
    wg1 = bti_pkg::ONE_Q12 - wg2;
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BG = b[1];
    localparam logic BT = b[0];
    logic [4:0]    gs;
    logic [5:0]    ts;
    logic [12:0]   wg, wt;
    logic          rd_in, wr_in, re, we;
    logic [AW-1:0] raddr, waddr;

    always_comb begin
      gs    = (g1[0] == BG) ? g1 : g2;
      wg    = (g1[0] == BG) ? wg1 : wg2;
      ts    = (t1[0] == BT) ? t1 : t2;
      wt    = (t1[0] == BT) ? wt1 : wt2;
      rd_in = (32'(gs) < GRAV_POINTS) && (32'(ts) < TEMP_POINTS) &&
              (32'(head.filt) < FILTERS);
      wr_in = (32'(head.gslot) < GRAV_POINTS) && (32'(head.tslot) < TEMP_POINTS) &&
              (32'(head.filt) < FILTERS);
      re    = lookup_pop && (status == bti_pkg::ST_OK) && rd_in;
      we    = q_pop && !is_lookup && wr_in &&
              (head.gslot[0] == BG) && (head.tslot[0] == BT);
      raddr = AW'((32'(gs[4:1]) * TH + 32'(ts[5:1])) * FILTERS + 32'(head.filt));
      waddr = AW'((32'(head.gslot[3:1]) * TH + 32'(head.tslot[4:1])) * FILTERS +
                  32'(head.filt));
    end

    bti_bank #(.DEPTH(BD), .AW(AW)) u_bank (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (head.value),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata[b])
    );

    always_ff @(posedge clk) begin
      s1_wg_r[b] <= wg;
      s1_wt_r[b] <= wt;
      s1_ok_r[b] <= re && (wg != '0) && (wt != '0);
      s2_ww_r[b] <= 26'(s1_wg_r[b]) * 26'(s1_wt_r[b]);
      s2_d_r[b]  <= s1_ok_r[b] ? rdata[b] : '0;
      s3_p_r[b]  <= 58'(s2_ww_r[b]) * 58'(s2_d_r[b]);
    end
  end

  always_ff @(posedge clk) begin
    s1_st_r <= status;
    s2_st_r <= s1_st_r;
    s3_st_r <= s2_st_r;
    s4_st_r <= s3_st_r;
    s4_a_r  <= s3_p_r[0] + s3_p_r[1];
    s4_b_r  <= s3_p_r[2] + s3_p_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s4_v_r    <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      s1_v_r    <= lookup_pop;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
    end
  end

  assign total    = s4_a_r + s4_b_r + 58'(1 << 23);
  assign res_push = s4_v_r;
  always_comb begin
    res_word.status    = s4_st_r;
    res_word.intensity = (s4_st_r == bti_pkg::ST_OK) ? total[55:24] : '0;
  end
endmodule

### hdl/bilinear_table_interpolator_unit.sv
// ----------------------------------------------------------------------------
// bilinear_table_interpolator_unit
// A lookup word passes the front register, input queue, bank, the s1 to s4
// registers and output queue. Throughput: one word per cycle when not stalled,
// set by the four parity banks that give all four neighbors in one read; a
// write word gives no result. Reset clears control state and loads register
// defaults; the table is undefined until written and gets no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bilinear_table_interpolator_unit #(
  parameter int TEMP_POINTS = 32,
  parameter int GRAV_POINTS = 16,
  parameter int FILTERS     = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [19:0] in_temperature,
  input  logic [15:0] in_log_gravity,
  input  logic [2:0]  in_filter_index,
  input  logic [3:0]  in_grav_slot,
  input  logic [4:0]  in_temp_slot,
  input  logic [31:0] in_entry_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_intensity,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  bti_pkg::cfg_t        cfg_r;
  logic                 cfg_we;
  bti_pkg::reg_index_t  reg_idx;
  logic                 fq_push, fq_pop, fq_full, fq_empty;
  bti_pkg::front_word_t fq_in, fq_head;
  logic                 rq_push, rq_full, rq_empty, res_taken;
  bti_pkg::result_t     rq_in, rq_head;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = bti_pkg::reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_origin <= 20'd56000;
      cfg_r.temp_inv    <= 24'd1073742;
      cfg_r.temp_last   <= 5'd18;
      cfg_r.grav_origin <= 16'd0;
      cfg_r.grav_inv    <= 24'd2097152;
      cfg_r.grav_last   <= 4'd10;
    end else if (cfg_we) begin
      case (reg_idx)
        bti_pkg::REG_TEMP_ORIGIN: cfg_r.temp_origin <= pwdata[19:0];
        bti_pkg::REG_TEMP_INV:    cfg_r.temp_inv    <= pwdata[23:0];
        bti_pkg::REG_TEMP_LAST:   cfg_r.temp_last   <= pwdata[4:0];
        bti_pkg::REG_GRAV_ORIGIN: cfg_r.grav_origin <= pwdata[15:0];
        bti_pkg::REG_GRAV_INV:    cfg_r.grav_inv    <= pwdata[23:0];
        bti_pkg::REG_GRAV_LAST:   cfg_r.grav_last   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bti_pkg::REG_TEMP_ORIGIN: prdata = 32'(cfg_r.temp_origin);
      bti_pkg::REG_TEMP_INV:    prdata = 32'(cfg_r.temp_inv);
      bti_pkg::REG_TEMP_LAST:   prdata = 32'(cfg_r.temp_last);
      bti_pkg::REG_GRAV_ORIGIN: prdata = 32'(cfg_r.grav_origin);
      bti_pkg::REG_GRAV_INV:    prdata = 32'(cfg_r.grav_inv);
      bti_pkg::REG_GRAV_LAST:   prdata = 32'(cfg_r.grav_last);
      default:                  prdata = '0;
    endcase
  end

  bti_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_temperature  (in_temperature),
    .in_log_gravity  (in_log_gravity),
    .in_filter_index (in_filter_index),
    .in_grav_slot    (in_grav_slot),
    .in_temp_slot    (in_temp_slot),
    .in_entry_value  (in_entry_value),
    .q_full          (fq_full),
    .q_push          (fq_push),
    .q_word          (fq_in)
  );

  bti_queue #(
    .WIDTH ($bits(bti_pkg::front_word_t)),
    .DEPTH (bti_pkg::IN_DEPTH)
  ) u_in_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_data (fq_in),
    .pop       (fq_pop),
    .head_data (fq_head),
    .empty     (fq_empty),
    .full      (fq_full)
  );

  bti_back #(
    .TEMP_POINTS (TEMP_POINTS),
    .GRAV_POINTS (GRAV_POINTS),
    .FILTERS     (FILTERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (fq_empty),
    .head      (fq_head),
    .q_pop     (fq_pop),
    .res_taken (res_taken),
    .res_push  (rq_push),
    .res_word  (rq_in)
  );

  bti_queue #(
    .WIDTH ($bits(bti_pkg::result_t)),
    .DEPTH (bti_pkg::OUT_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rq_push),
    .push_data (rq_in),
    .pop       (res_taken),
    .head_data (rq_head),
    .empty     (rq_empty),
    .full      (rq_full)
  );

  assign out_valid     = !rq_empty;
  assign res_taken     = out_valid && !out_stall && !(rq_full && 1'b0);
  assign out_intensity = rq_head.intensity;
  assign out_status    = rq_head.status;
endmodule

### hdl/bti_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_checker
// Port-level checks of the bilinear table interpolator.
// ----------------------------------------------------------------------------
module bti_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_intensity,
  input logic [1:0]  out_status,
  input logic        pready
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_intensity) && $stable(out_status))
    else $error("stalled output word changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == bti_pkg::ST_OK || out_status == bti_pkg::ST_TEMP_LOW ||
                   out_status == bti_pkg::ST_TEMP_HIGH))
    else $error("undefined status code");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bti_pkg::ST_OK |-> out_intensity == 32'd0)
    else $error("nonzero intensity with error status");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && pready)
    else $error("output valid right after reset");
endmodule

bind bilinear_table_interpolator_unit bti_checker u_bti_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_intensity (out_intensity),
  .out_status    (out_status),
  .pready        (pready)
);
